[design/ssd_pkg.sv]
package ssd_pkg;

  // Command codes
  localparam logic [3:0] CMD_INIT        = 4'd0;
  localparam logic [3:0] CMD_NUMBER      = 4'd1;
  localparam logic [3:0] CMD_HEX         = 4'd2;
  localparam logic [3:0] CMD_RAW         = 4'd3;
  localparam logic [3:0] CMD_CLEAR_DIGIT = 4'd4;
  localparam logic [3:0] CMD_CLEAR_ALL   = 4'd5;
  localparam logic [3:0] CMD_BRIGHT      = 4'd6;
  localparam logic [3:0] CMD_POWER       = 4'd7;
  localparam logic [3:0] CMD_KEY         = 4'd8;

  // Controller register map
  localparam logic [6:0] CTRL_ADDR  = 7'h24;
  localparam logic [6:0] KEY_ADDR   = 7'h27;
  localparam logic [6:0] DIGIT_BASE = 7'h34;
  localparam logic [7:0] DP_BIT     = 8'h80;

  // Control byte handling
  localparam logic [7:0] INIT_SHADOW = 8'h41;
  localparam logic [7:0] BRIGHT_KEEP = 8'h8F;
  localparam logic [7:0] LEVEL_MAX   = 8'd7;

  // Range limits
  localparam logic [15:0] NUM_MAX = 16'd9999;
  localparam logic [15:0] HEX_MAX = 16'd15;

  // Decimal conversion: four places, remainder fits 14 bits below 10000
  localparam int NUM_PLACES = 4;
  localparam int PLACE_W    = 2;
  localparam int REM_W      = 14;

  // Shadow store geometry
  localparam int SHADOW_W     = 8;
  localparam int SHADOW_DEPTH = 1;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] value;
    logic [7:0]  position;
    logic        dot;
    logic [7:0]  segments;
    logic [7:0]  level;
    logic        turn_on;
    logic [7:0]  key_byte;
  } req_t;

  typedef struct packed {
    logic       bus_write;
    logic [6:0] bus_addr;
    logic [7:0] bus_data;
    logic [5:0] key_id;
    logic       key_pressed;
    logic       status;
    logic       last;
  } rsp_t;

  typedef enum logic [1:0] {
    JOB_SINGLE,
    JOB_INIT,
    JOB_NUMBER,
    JOB_CLEAR
  } job_kind_t;

  // Work handed from the decoder to the beat sequencer
  typedef struct packed {
    job_kind_t        kind;
    rsp_t             res;
    logic [REM_W-1:0] rem;
  } job_t;

  function automatic logic [7:0] seg_font(input logic [3:0] digit);
    logic [7:0] pattern;
    begin
      case (digit)
        4'h0: pattern = 8'h3F;
        4'h1: pattern = 8'h06;
        4'h2: pattern = 8'h5B;
        4'h3: pattern = 8'h4F;
        4'h4: pattern = 8'h66;
        4'h5: pattern = 8'h6D;
        4'h6: pattern = 8'h7D;
        4'h7: pattern = 8'h07;
        4'h8: pattern = 8'h7F;
        4'h9: pattern = 8'h6F;
        4'hA: pattern = 8'h77;
        4'hB: pattern = 8'h7C;
        4'hC: pattern = 8'h39;
        4'hD: pattern = 8'h5E;
        4'hE: pattern = 8'h79;
        default: pattern = 8'h71;
      endcase
      return pattern;
    end
  endfunction

  function automatic rsp_t rsp_write(input logic [6:0] addr, input logic [7:0] data,
                                     input logic is_last);
    rsp_t r;
    begin
      r = '0;
      r.bus_write = 1'b1;
      r.bus_addr  = addr;
      r.bus_data  = data;
      r.last      = is_last;
      return r;
    end
  endfunction

  function automatic rsp_t rsp_reject();
    rsp_t r;
    begin
      r = '0;
      r.status = 1'b1;
      r.last   = 1'b1;
      return r;
    end
  endfunction

endpackage

[design/ssd_ram.sv]
module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port (read sees the old word)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ssd_front.sv]
module ssd_front import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);

  localparam int SAW = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;

  logic                front_valid;
  req_t                front;
  logic                job_take;
  logic                shadow_we;
  logic [SHADOW_W-1:0] shadow_new;
  logic [SHADOW_W-1:0] shadow_rd;
  logic [SHADOW_W-1:0] shadow_cur;
  logic                fwd_valid;
  logic [SHADOW_W-1:0] fwd_data;
  logic                written;
  logic                pos_ok;
  logic [6:0]          pos_addr;
  logic [2:0]          lvl;

  assign job_take  = front_valid && job_ready;
  assign req_ready = !front_valid || job_take;
  assign job_valid = front_valid;

  // Hold one command beat until the sequencer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      front_valid <= 1'b1;
    end else if (job_take) begin
      front_valid <= 1'b0;
    end
    if (req_valid && req_ready) begin
      front <= req;
    end
  end

  // Control shadow store, read every cycle
  ssd_ram #(
    .WIDTH (SHADOW_W),
    .DEPTH (SHADOW_DEPTH)
  ) u_shadow (
    .clk   (clk),
    .we    (shadow_we && job_take),
    .waddr (SAW'(0)),
    .wdata (shadow_new),
    .raddr (SAW'(0)),
    .rdata (shadow_rd)
  );

  // Forward last cycle's write; the store reads as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      written   <= 1'b0;
    end else begin
      fwd_valid <= shadow_we && job_take;
      if (shadow_we && job_take) begin
        written <= 1'b1;
      end
    end
    fwd_data <= shadow_new;
  end

  assign shadow_cur = fwd_valid ? fwd_data : (written ? shadow_rd : '0);

  assign pos_ok   = front.position < 8'(DIGIT_COUNT);
  assign pos_addr = DIGIT_BASE + front.position[6:0];
  assign lvl      = (front.level > LEVEL_MAX) ? LEVEL_MAX[2:0] : front.level[2:0];

  // Decode the command into a job and the new control byte
  always_comb begin
    job        = '0;
    job.kind   = JOB_SINGLE;
    job.res    = rsp_reject();
    shadow_we  = 1'b0;
    shadow_new = shadow_cur;
    case (front.cmd)
      CMD_INIT: begin
        shadow_new = INIT_SHADOW;
        shadow_we  = 1'b1;
        job.kind   = JOB_INIT;
        job.res    = rsp_write(CTRL_ADDR, INIT_SHADOW, 1'b0);
      end
      CMD_NUMBER: begin
        if (front.value <= NUM_MAX) begin
          job.kind = JOB_NUMBER;
          job.rem  = front.value[REM_W-1:0];
        end
      end
      CMD_HEX: begin
        if (front.value <= HEX_MAX && pos_ok) begin
          job.res = rsp_write(pos_addr,
                              seg_font(front.value[3:0]) | (front.dot ? DP_BIT : 8'h00),
                              1'b1);
        end
      end
      CMD_RAW: begin
        if (pos_ok) begin
          job.res = rsp_write(pos_addr, front.segments, 1'b1);
        end
      end
      CMD_CLEAR_DIGIT: begin
        if (pos_ok) begin
          job.res = rsp_write(pos_addr, 8'h00, 1'b1);
        end
      end
      CMD_CLEAR_ALL: begin
        job.kind = JOB_CLEAR;
      end
      CMD_BRIGHT: begin
        shadow_new = (shadow_cur & BRIGHT_KEEP) | {1'b0, lvl, 4'b0000};
        shadow_we  = 1'b1;
        job.res    = rsp_write(CTRL_ADDR, shadow_new, 1'b1);
      end
      CMD_POWER: begin
        shadow_new = {shadow_cur[7:1], front.turn_on};
        shadow_we  = 1'b1;
        job.res    = rsp_write(CTRL_ADDR, shadow_new, 1'b1);
      end
      CMD_KEY: begin
        job.res             = '0;
        job.res.bus_addr    = KEY_ADDR;
        job.res.key_id      = front.key_byte[5:0];
        job.res.key_pressed = front.key_byte[6];
        job.res.last        = 1'b1;
      end
      default: begin
        job.res = rsp_reject();
      end
    endcase
  end

endmodule

[design/ssd_emit.sv]
module ssd_emit import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CNT_MAX = (DIGIT_COUNT > NUM_PLACES - 1) ? DIGIT_COUNT : NUM_PLACES - 1;
  localparam int CW      = $clog2(CNT_MAX + 1);

  logic               busy;
  job_kind_t          kind;
  rsp_t               single;
  logic [CW-1:0]      cnt;
  logic [REM_W-1:0]   rem;
  logic               lead;

  logic [PLACE_W-1:0] place;
  logic [3:0]         digit;
  logic [REM_W-1:0]   sub;
  logic [REM_W-1:0]   thr;
  logic [REM_W-1:0]   rem_next;
  logic               blank;
  logic               lead_next;
  logic               beat_valid;
  rsp_t               beat;
  logic               out_free;
  logic               step;
  logic               finish;
  logic               job_take;

  assign place = PLACE_W'(NUM_PLACES - 1) - cnt[PLACE_W-1:0];

  // Pick the decimal digit at the current place by comparing with its multiples
  always_comb begin
    digit = 4'd0;
    sub   = '0;
    thr   = '0;
    for (int k = 1; k <= 9; k++) begin
      case (place)
        2'd0:    thr = REM_W'(k);
        2'd1:    thr = REM_W'(k * 10);
        2'd2:    thr = REM_W'(k * 100);
        default: thr = REM_W'(k * 1000);
      endcase
      if (rem >= thr) begin
        digit = 4'(k);
        sub   = thr;
      end
    end
  end

  assign rem_next = rem - sub;
  assign blank    = lead && (digit == 4'd0) && (place != '0);

  // Build the beat for the current step
  always_comb begin
    beat       = single;
    beat_valid = busy;
    lead_next  = lead;
    case (kind)
      JOB_SINGLE: begin
        beat = single;
      end
      JOB_INIT: begin
        if (cnt != '0) begin
          beat = rsp_write(DIGIT_BASE + 7'(cnt) - 7'd1, 8'h00, cnt == CW'(DIGIT_COUNT));
        end
      end
      JOB_CLEAR: begin
        beat = rsp_write(DIGIT_BASE + 7'(cnt), 8'h00, cnt == CW'(DIGIT_COUNT - 1));
      end
      JOB_NUMBER: begin
        // Places at or above the digit count are stepped through without a beat
        beat_valid = busy && ({1'b0, place} < 3'(DIGIT_COUNT));
        beat       = rsp_write(DIGIT_BASE + 7'(DIGIT_COUNT - 1) - 7'(place),
                               blank ? 8'h00 : seg_font(digit), place == '0);
        if (beat_valid) begin
          lead_next = blank;
        end
      end
      default: begin
        beat = single;
      end
    endcase
  end

  assign out_free  = !rsp_valid || rsp_ready;
  assign step      = busy && (!beat_valid || out_free);
  assign finish    = step && beat_valid && beat.last;
  assign job_ready = !busy || finish;
  assign job_take  = job_valid && job_ready;

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (job_take) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
    if (job_take) begin
      kind   <= job.kind;
      single <= job.res;
      rem    <= job.rem;
      cnt    <= '0;
      lead   <= 1'b1;
    end else if (step) begin
      cnt  <= cnt + CW'(1);
      rem  <= rem_next;
      lead <= lead_next;
    end
  end

  // Output register: load a beat whenever it is free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (step && beat_valid) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (step && beat_valid) begin
      rsp <= beat;
    end
  end

endmodule

[design/seven_segment_display_command_encoder_top.sv]
// Channel  Signals                        Beat
// -------  -----------------------------  ------------------------------------
// req      req_valid, req_ready, req      one display command (req_t)
// rsp      rsp_valid, rsp_ready, rsp      one bus write, key result or reject
//
// With the sequencer idle, a command's first beat passes the input stage, sequencer and output
// register. The sequencer emits one beat per cycle unless rsp stalls: single-result 1, init
// 1+DIGIT_COUNT, clear all DIGIT_COUNT, number one per place below DIGIT_COUNT of its four places.
// Reset clears all valid flags; the control shadow reads as zero until written.
// A stalled rsp holds its beat; one command waits in the input stage meanwhile.
module seven_segment_display_command_encoder_top import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic job_valid;
  logic job_ready;
  job_t job;

  // Decode and control shadow
  ssd_front #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // Beat sequencer and output register
  ssd_emit #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
